// ----- sv/tri_pkg.sv -----
// Shared types and constants for the turn radius interpolator.
package tri_pkg;

  localparam int unsigned MaxPoints  = 7;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QuoBits    = 16;

  // Configuration register indexes
  localparam logic [2:0] CfgPointCount = 3'd0;
  localparam logic [2:0] CfgPoint0     = 3'd1;

  // One classified query as handed from the front to the back.
  typedef struct packed {
    logic        interp;
    logic [15:0] r_lo;
    logic [15:0] dx;
    logic [15:0] den;
    logic        neg;
    logic [15:0] dr_mag;
  } entry_t;

endpackage

// ----- sv/tri_speed_if.sv -----
// Query channel: carries one signed Q8.8 speed per item.
interface tri_speed_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] speed;

  modport source (output valid, output speed, input ready);
  modport sink (input valid, input speed, output ready);
endinterface

// ----- sv/tri_radius_if.sv -----
// Result channel: carries one unsigned Q10.6 radius per item.
interface tri_radius_if;
  logic        valid;
  logic        ready;
  logic [15:0] radius;

  modport source (output valid, output radius, input ready);
  modport sink (input valid, input radius, output ready);
endinterface

// ----- sv/tri_cfg_if.sv -----
// Configuration write channel: register index and write data.
interface tri_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/turn_radius_interpolator_top.sv -----
// Top level of the turn radius interpolator: front, queue and back.
//
//   channel  | dir | payload                       | accepted when
//   cfg_i    | in  | index [2:0], data [31:0]       | valid && ready (ready tied high)
//   speed_i  | in  | speed signed Q8.8 [15:0]      | valid && ready
//   radius_o | out | radius unsigned Q10.6 [15:0]  | valid && ready
//
// A query at an end point or an exact breakpoint is popped from the queue and its radius
// goes to the result register; an interpolated one is popped, takes one 16x16 multiply and
// the bit-serial divide, then forms the result. The divider sets the rate.
// The queue holds QUEUE_DEPTH classified queries, so the input keeps accepting until it is
// full, while the back divides or its result waits; the result register frees the back.
// Reset clears control state and all breakpoint registers; no clearing pass.
module turn_radius_interpolator_top #(
  parameter int unsigned MAX_POINTS  = tri_pkg::MaxPoints,
  parameter int unsigned QUEUE_DEPTH = tri_pkg::QueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tri_cfg_if.sink      cfg_i,
  tri_speed_if.sink    speed_i,
  tri_radius_if.source radius_o
);
  import tri_pkg::*;

  logic   push;
  logic   q_full;
  entry_t front_entry;
  logic   pop;
  logic   q_empty;
  entry_t back_entry;

  tri_front #(
    .MAX_POINTS (MAX_POINTS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_i),
    .speed_i  (speed_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (front_entry)
  );

  tri_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .data_o  (back_entry),
    .empty_o (q_empty)
  );

  tri_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .entry_i   (back_entry),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .radius_o  (radius_o)
  );

endmodule

// ----- sv/tri_fifo.sv -----
// Short queue of classified queries between the front and the back.
module tri_fifo #(
  parameter int unsigned DEPTH = tri_pkg::QueueDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tri_pkg::entry_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output tri_pkg::entry_t data_o,
  output logic            empty_o
);
  import tri_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  entry_t          mem_q [DEPTH];
  logic [AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]   count_q, count_d;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the queue");
`endif

endmodule

// ----- sv/tri_front.sv -----
// Front: configuration registers, breakpoint search and query classification.
module tri_front #(
  parameter int unsigned MAX_POINTS = tri_pkg::MaxPoints
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  tri_cfg_if.sink         cfg_i,
  tri_speed_if.sink       speed_i,
  input  logic            q_full_i,
  output logic            push_o,
  output tri_pkg::entry_t entry_o
);
  import tri_pkg::*;

  localparam int unsigned PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  logic [2:0]         count_q;
  logic [31:0]        points_q [MAX_POINTS];

  logic [2:0]         pt_off;
  logic               pt_wr;
  logic [2:0]         n;
  logic               found;
  logic [PW-1:0]      hi_idx;
  logic [PW-1:0]      lo_idx;
  logic signed [15:0] q;
  logic signed [15:0] s_0, s_lo, s_hi;
  logic [15:0]        r_0, r_lo, r_hi;
  logic signed [16:0] dx_w, den_w, dr_w;
  logic [16:0]        dr_abs;

  // Register file
  assign cfg_i.ready = 1'b1;
  assign pt_off      = cfg_i.index - CfgPoint0;
  assign pt_wr       = (cfg_i.index != CfgPointCount) && (32'(pt_off) < 32'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      for (int i = 0; i < int'(MAX_POINTS); i++) begin
        points_q[i] <= '0;
      end
    end else if (cfg_i.valid) begin
      if (cfg_i.index == CfgPointCount) begin
        count_q <= cfg_i.data[2:0];
      end else if (pt_wr) begin
        points_q[pt_off[PW-1:0]] <= cfg_i.data;
      end
    end
  end

  // Breakpoint search: first point above point 0 whose speed is not below q
  assign q = speed_i.speed;
  assign n = (count_q > 3'(MAX_POINTS)) ? 3'(MAX_POINTS) : count_q;

  always_comb begin
    found  = 1'b0;
    hi_idx = '0;
    for (int i = int'(MAX_POINTS) - 1; i >= 1; i--) begin
      if ((3'(i) < n) && !($signed(points_q[i][31:16]) < q)) begin
        found  = 1'b1;
        hi_idx = PW'(i);
      end
    end
    lo_idx = found ? (hi_idx - PW'(1)) : PW'(n - 3'd1);
  end

  assign s_0  = $signed(points_q[0][31:16]);
  assign r_0  = points_q[0][15:0];
  assign s_lo = $signed(points_q[lo_idx][31:16]);
  assign r_lo = points_q[lo_idx][15:0];
  assign s_hi = $signed(points_q[hi_idx][31:16]);
  assign r_hi = points_q[hi_idx][15:0];

  assign dx_w   = {q[15], q} - {s_lo[15], s_lo};
  assign den_w  = {s_hi[15], s_hi} - {s_lo[15], s_lo};
  assign dr_w   = $signed({1'b0, r_hi}) - $signed({1'b0, r_lo});
  assign dr_abs = dr_w[16] ? 17'(-dr_w) : 17'(dr_w);

  // Classify: an empty table, end points and exact hits give the radius outright
  always_comb begin
    entry_o = '0;
    if (n == 3'd0) begin
      entry_o.r_lo = '0;
    end else if ((n == 3'd1) || (q <= s_0)) begin
      entry_o.r_lo = r_0;
    end else if (!found) begin
      entry_o.r_lo = r_lo;
    end else if (s_hi == q) begin
      entry_o.r_lo = r_hi;
    end else begin
      entry_o.interp = 1'b1;
      entry_o.r_lo   = r_lo;
      entry_o.dx     = dx_w[15:0];
      entry_o.den    = den_w[15:0];
      entry_o.neg    = dr_w[16];
      entry_o.dr_mag = dr_abs[15:0];
    end
  end

  assign speed_i.ready = !q_full_i;
  assign push_o        = speed_i.valid && !q_full_i;

endmodule

// ----- sv/tri_back.sv -----
// Back: multiply, restoring divide one quotient bit per cycle, result register.
module tri_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tri_pkg::entry_t entry_i,
  input  logic            q_empty_i,
  output logic            pop_o,
  tri_radius_if.source    radius_o
);
  import tri_pkg::*;

  localparam int unsigned NW = $clog2(QuoBits);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_DONE} state_e;

  state_e         state_q, state_d;
  entry_t         ent_q, ent_d;
  logic [15:0]    rem_q, rem_d;
  logic [15:0]    low_q, low_d;
  logic [15:0]    quo_q, quo_d;
  logic [NW-1:0]  cnt_q, cnt_d;
  logic           out_valid_q, out_valid_d;
  logic [15:0]    out_radius_q, out_radius_d;

  logic [31:0]    prod;
  logic [16:0]    trial;
  logic           take;
  logic [15:0]    res;
  logic           out_free;

  assign prod     = ent_q.dx * ent_q.dr_mag;
  assign trial    = {rem_q, low_q[15]};
  assign take     = (trial >= {1'b0, ent_q.den});
  assign res      = ent_q.neg ? (ent_q.r_lo - quo_q) : (ent_q.r_lo + quo_q);
  assign out_free = !out_valid_q || radius_o.ready;
  assign pop_o    = (state_q == S_IDLE) && !q_empty_i;

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    rem_d        = rem_q;
    low_d        = low_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q;
    out_radius_d = out_radius_q;
    if (out_valid_q && radius_o.ready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          ent_d   = entry_i;
          quo_d   = '0;
          state_d = entry_i.interp ? S_MUL : S_DONE;
        end
      end
      S_MUL: begin
        // Upper half is below the divisor, so the quotient fits in QuoBits
        rem_d   = prod[31:16];
        low_d   = prod[15:0];
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = take ? 16'(trial - {1'b0, ent_q.den}) : trial[15:0];
        low_d = {low_q[14:0], 1'b0};
        quo_d = {quo_q[14:0], take};
        cnt_d = cnt_q + NW'(1);
        if (cnt_q == NW'(QuoBits - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_radius_d = res;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ent_q        <= '0;
      rem_q        <= '0;
      low_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
      out_radius_q <= '0;
    end else begin
      state_q      <= state_d;
      ent_q        <= ent_d;
      rem_q        <= rem_d;
      low_q        <= low_d;
      quo_q        <= quo_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
      out_radius_q <= out_radius_d;
    end
  end

  assign radius_o.valid  = out_valid_q;
  assign radius_o.radius = out_radius_q;

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < ent_q.den))
    else $error("partial remainder not below divisor");
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) |-> (quo_q <= ent_q.dr_mag))
    else $error("correction exceeds radius span");
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_DONE))
    else $error("result raised outside done state");
`endif

endmodule

// ----- verif/turn_radius_interpolator_top_test.sv -----
`timescale 1ns / 1ps
// Testbench for the turn radius interpolator: table lookups checked against a local predictor.
module turn_radius_interpolator_top_test;
  import tri_pkg::*;

  localparam int unsigned HoldOff    = 24;
  localparam int unsigned StallLimit = 4000;
  localparam int          NumPoints  = int'(MaxPoints);

  typedef struct packed {
    logic [15:0] speed;
    logic [15:0] radius;
  } lookup_t;

  logic clk;
  logic rst_n;

  tri_cfg_if    cfg ();
  tri_speed_if  spd ();
  tri_radius_if rad ();

  // Local copy of the breakpoint table, updated as each write is accepted.
  logic [2:0]  table_count;
  logic [31:0] table_points  [NumPoints];
  logic [31:0] staged_points [NumPoints];

  lookup_t radius_queue [$];
  lookup_t radius_want;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      mismatches;
  int      stall_cycles;

  turn_radius_interpolator_top DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg),
    .speed_i  (spd),
    .radius_o (rad)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int speed_at(int i);
    return int'($signed(table_points[i][31:16]));
  endfunction

  function automatic int radius_at(int i);
    return int'({16'd0, table_points[i][15:0]});
  endfunction

  function automatic logic [31:0] point_word(int s, int r);
    return {s[15:0], r[15:0]};
  endfunction

  function automatic logic [15:0] predict_radius(int q);
    int     n;
    int     lo;
    int     hi;
    longint dx;
    longint den;
    longint dr;
    longint corr;
    longint sum;
    n = int'(table_count);
    if (n > NumPoints) n = NumPoints;
    if (n == 0) return 16'd0;
    if (n == 1) return 16'(radius_at(0));
    if (q <= speed_at(0)) return 16'(radius_at(0));
    lo = 0;
    hi = 1;
    while (hi < n && speed_at(hi) < q) begin
      lo = hi;
      hi++;
    end
    if (hi >= n) return 16'(radius_at(lo));
    if (speed_at(hi) <= q) return 16'(radius_at(hi));
    dx  = longint'(q) - longint'(speed_at(lo));
    den = longint'(speed_at(hi)) - longint'(speed_at(lo));
    dr  = longint'(radius_at(hi)) - longint'(radius_at(lo));
    if (den <= 0) return 16'(radius_at(lo));
    // multiply first, then truncate toward zero
    corr = (dx * dr) / den;
    sum  = longint'(radius_at(lo)) + corr;
    return sum[15:0];
  endfunction

  // Call right after a rising edge; leaves valid high for a back-to-back item.
  task automatic send_speed(input int q);
    logic [15:0] q16;
    lookup_t     entry;
    q16 = q[15:0];
    while ($urandom_range(99) < send_idle_pct) begin
      spd.valid <= 1'b0;
      @(posedge clk);
    end
    spd.valid <= 1'b1;
    spd.speed <= q16;
    @(posedge clk);
    while (!spd.ready) @(posedge clk);
    entry.speed  = q16;
    entry.radius = predict_radius(int'($signed(q16)));
    radius_queue = {radius_queue, entry};
  endtask

  // Hold the query channel until every expected radius has come back.
  task automatic drain_results();
    spd.valid <= 1'b0;
    while (radius_queue.size() != 0) @(posedge clk);
    repeat (HoldOff) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    if (idx == CfgPointCount) begin
      table_count = data[2:0];
    end else begin
      table_points[idx - CfgPoint0] = data;
    end
  endtask

  task automatic program_table(input int count);
    logic [31:0] word;
    drain_results();
    // upper bits of the count register carry noise and must be dropped
    word      = $urandom();
    word[2:0] = count[2:0];
    write_reg(CfgPointCount, word);
    for (int i = 0; i < NumPoints; i++) begin
      write_reg(CfgPoint0 + 3'(i), staged_points[i]);
    end
    cfg.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_speed(-32768);
    send_speed(32767);
  endtask

  task automatic test_single_point();
    foreach (staged_points[i]) staged_points[i] = $urandom();
    staged_points[0] = point_word(-32768, 65535);
    program_table(1);
    send_speed(-32768);
    send_speed(32767);
  endtask

  task automatic test_full_table();
    staged_points[0] = point_word(-32768, 65535);
    staged_points[1] = point_word(-1000, 0);
    staged_points[2] = point_word(-999, 65535);
    staged_points[3] = point_word(0, 1234);
    staged_points[4] = point_word(256, 0);
    staged_points[5] = point_word(20000, 40000);
    staged_points[6] = point_word(32767, 65535);
    program_table(7);
    send_speed(-32768);
    send_speed(-20000);
    send_speed(-1000);
    send_speed(-999);
    send_speed(-500);
    send_speed(0);
    send_speed(100);
    send_speed(256);
    send_speed(10000);
    send_speed(20000);
    send_speed(30000);
    send_speed(32767);
  endtask

  task automatic test_end_points();
    foreach (staged_points[i]) staged_points[i] = $urandom();
    staged_points[0] = point_word(-100, 500);
    staged_points[1] = point_word(0, 65535);
    staged_points[2] = point_word(100, 7);
    program_table(3);
    send_speed(-32768);
    send_speed(50);
    send_speed(150);
    send_speed(32767);
  endtask

  task automatic test_unordered_table();
    foreach (staged_points[i]) staged_points[i] = $urandom();
    staged_points[0] = point_word(50, 100);
    staged_points[1] = point_word(50, 200);
    staged_points[2] = point_word(-10, 300);
    staged_points[3] = point_word(300, 400);
    program_table(4);
    send_speed(50);
    send_speed(200);
    send_speed(400);
  endtask

  task automatic test_random_tables(input int items);
    int vals [NumPoints];
    int sent;
    int count;
    int queries;
    int style;
    int lo_s;
    int hi_s;
    int a;
    int r;
    int s;
    int v;
    int tmp;
    bit dup;
    bit pressure_done;
    sent          = 0;
    pressure_done = 1'b0;
    while (sent < items) begin
      count = ($urandom_range(3) == 0) ? $urandom_range(0, 7) : $urandom_range(2, 7);
      style = $urandom_range(9);
      if (style == 0) begin
        // unordered, with repeated speeds now and then
        for (int i = 0; i < NumPoints; i++) begin
          if (i > 0 && $urandom_range(3) == 0) vals[i] = vals[i-1];
          else vals[i] = int'($urandom_range(0, 65535)) - 32768;
        end
      end else if (style <= 3) begin
        // tight cluster: small divisors
        vals[0] = int'($urandom_range(0, 65535 - 120)) - 32768;
        for (int i = 1; i < NumPoints; i++) vals[i] = vals[i-1] + int'($urandom_range(1, 16));
      end else begin
        for (int i = 0; i < NumPoints; i++) begin
          do begin
            v   = int'($urandom_range(0, 65535)) - 32768;
            dup = 1'b0;
            for (int j = 0; j < i; j++) if (vals[j] == v) dup = 1'b1;
          end while (dup);
          vals[i] = v;
        end
        for (int i = 1; i < NumPoints; i++) begin
          for (int j = i; j > 0 && vals[j-1] > vals[j]; j--) begin
            tmp       = vals[j];
            vals[j]   = vals[j-1];
            vals[j-1] = tmp;
          end
        end
      end
      for (int i = 0; i < NumPoints; i++) begin
        case ($urandom_range(7))
          0:       r = 0;
          1:       r = 65535;
          default: r = int'($urandom_range(0, 65535));
        endcase
        staged_points[i] = point_word(vals[i], r);
      end
      program_table(count);
      queries = $urandom_range(20, 60);
      if (queries > items - sent) queries = items - sent;
      repeat (queries) begin
        case ($urandom_range(9))
          0, 1, 2, 3: begin
            s = vals[$urandom_range(NumPoints - 1)] + int'($urandom_range(0, 4)) - 2;
          end
          4, 5, 6, 7: begin
            a    = $urandom_range(NumPoints - 2);
            lo_s = (vals[a] < vals[a+1]) ? vals[a] : vals[a+1];
            hi_s = (vals[a] < vals[a+1]) ? vals[a+1] : vals[a];
            s    = lo_s + int'($urandom_range(0, hi_s - lo_s));
          end
          default: s = $urandom();
        endcase
        send_speed(s);
        sent++;
        if (!pressure_done && sent == 10) begin
          drain_results();
          pressure_done = 1'b1;
        end
      end
    end
  endtask

  // Result checker and receiver back-pressure.
  always @(posedge clk) begin
    if (rst_n && rad.valid && rad.ready) begin
      if (radius_queue.size() == 0) begin
        if (mismatches < 10) $display("radius %h arrived with no query pending", rad.radius);
        mismatches++;
      end else begin
        radius_want = radius_queue.pop_front();
        if (rad.radius !== radius_want.radius) begin
          if (mismatches < 10) begin
            $display("speed %0d: radius expected %h, got %h",
                     $signed(radius_want.speed), radius_want.radius, rad.radius);
          end
          mismatches++;
        end
      end
    end
    rad.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // End the run when no channel moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (spd.valid && spd.ready) || (rad.valid && rad.ready) ||
        (cfg.valid && cfg.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg.valid     = 1'b0;
    cfg.index     = '0;
    cfg.data      = '0;
    spd.valid     = 1'b0;
    spd.speed     = '0;
    rad.ready     = 1'b0;
    table_count   = '0;
    foreach (table_points[i]) table_points[i] = '0;
    mismatches    = 0;
    stall_cycles  = 0;
    send_idle_pct = 23;
    recv_idle_pct = 70;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_single_point();
    test_full_table();
    test_end_points();
    test_unordered_table();
    test_random_tables(284);

    drain_results();
    send_idle_pct = 70;
    recv_idle_pct = 23;
    test_random_tables(284);

    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_tables(284);

    drain_results();
    if (mismatches == 0 && radius_queue.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
